// ===== design/ptc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the barometer compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int RAW_W      = 24;
	localparam int CAL_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int TEMP_OUT_W = 19;
	localparam int PRES_OUT_W = 32;
	localparam int NUM_STAGES = 9;

	// Temperature thresholds in hundredths of a degree
	localparam int TEMP_REF  = 2000;
	localparam int TEMP_COLD = -1500;

	// Second-order correction coefficients
	localparam int OFF2_A_COEF  = 61;
	localparam int SENS2_A_COEF = 29;
	localparam int OFF2_B_COEF  = 17;
	localparam int SENS2_B_COEF = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SENS_T1   = 3'd0,
		CFG_OFF_T1    = 3'd1,
		CFG_TCS       = 3'd2,
		CFG_TCO       = 3'd3,
		CFG_T_REF     = 3'd4,
		CFG_TEMP_SENS = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [CAL_W-1:0] sens_t1;
		logic [CAL_W-1:0] off_t1;
		logic [CAL_W-1:0] tcs;
		logic [CAL_W-1:0] tco;
		logic [CAL_W-1:0] t_ref;
		logic [CAL_W-1:0] temp_sens;
	} cal_t;

	// Hand-off from the temperature half to the pressure half (stage 4)
	typedef struct packed {
		logic             inv;
		logic             a_neg;    // TEMP below 20.00 C
		logic             b_neg;    // TEMP below -15.00 C
		logic [RAW_W-1:0] d1;
		logic [20:0]      t_out;    // TEMP - T2, signed
		logic [36:0]      off_lin;  // first-order offset, signed
		logic [35:0]      sens_lin; // first-order sensitivity, signed
		logic [33:0]      a2;       // (TEMP - 2000)^2
		logic [34:0]      b2;       // (TEMP + 1500)^2
	} corr_t;

endpackage

// ===== design/ptc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_cfg_regs
// Calibration word registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module ptc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptc_pkg::CAL_W-1:0]      cfg_data,
	output ptc_pkg::cal_t                  cal
);
	import ptc_pkg::*;

	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SENS_T1:   cal_q.sens_t1   <= cfg_data;
				CFG_OFF_T1:    cal_q.off_t1    <= cfg_data;
				CFG_TCS:       cal_q.tcs       <= cfg_data;
				CFG_TCO:       cal_q.tco       <= cfg_data;
				CFG_T_REF:     cal_q.t_ref     <= cfg_data;
				CFG_TEMP_SENS: cal_q.temp_sens <= cfg_data;
				default:       cal_q           <= cal_q; // drop unknown index
			endcase
		end
	end

	assign cal = cal_q;

endmodule

// ===== design/ptc_pipe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pipe_ctrl
// Valid bits and per-stage load enables; a stage loads when empty or when
// the stage after it moves on, so bubbles close up under an output stall.
// ----------------------------------------------------------------------------
module ptc_pipe_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            out_stall,
	output logic [ptc_pkg::NUM_STAGES-1:0]  en,
	output logic                            in_stall,
	output logic                            out_valid
);
	import ptc_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES:0]   go;

	always_comb begin
		go[NUM_STAGES] = !out_stall;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			go[k] = !vld_q[k] || go[k+1];
		end
	end

	assign en = go[NUM_STAGES-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = vld_q[NUM_STAGES-1];

endmodule

// ===== design/ptc_temp_path.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_temp_path
// Stages 1 to 4: dT, the dT products, TEMP and T2, first-order OFF and SENS,
// and the squares used by the second-order correction.
// ----------------------------------------------------------------------------
module ptc_temp_path (
	input  logic                            clk,
	input  logic [ptc_pkg::NUM_STAGES-1:0]  en,
	input  ptc_pkg::cal_t                   cal,
	input  logic [ptc_pkg::RAW_W-1:0]       raw_pressure,
	input  logic [ptc_pkg::RAW_W-1:0]       raw_temperature,
	output ptc_pkg::corr_t                  corr
);
	import ptc_pkg::*;

	// Stage 1
	logic signed [24:0] dt_c;
	logic               inv_c;
	logic [RAW_W-1:0]   d1_s1;
	logic signed [24:0] dt_s1;
	logic               inv_s1;

	assign dt_c  = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.t_ref, 8'h00});
	assign inv_c = (raw_pressure == '0) || (raw_temperature == '0);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d1_s1  <= raw_pressure;
			dt_s1  <= dt_c;
			inv_s1 <= inv_c;
		end
	end

	// Stage 2: the four multiplies by dT
	logic signed [49:0] sq_c;
	logic [RAW_W-1:0]   d1_s2;
	logic               inv_s2;
	logic signed [41:0] m_ts_s2;
	logic [47:0]        m_sq_s2;
	logic signed [41:0] m_tco_s2;
	logic signed [41:0] m_tcs_s2;

	assign sq_c = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d1_s2    <= d1_s1;
			inv_s2   <= inv_s1;
			m_ts_s2  <= dt_s1 * $signed({1'b0, cal.temp_sens});
			m_sq_s2  <= sq_c[47:0];
			m_tco_s2 <= $signed({1'b0, cal.tco}) * dt_s1;
			m_tcs_s2 <= $signed({1'b0, cal.tcs}) * dt_s1;
		end
	end

	// Stage 3: shifts, TEMP, T2 and first-order terms
	logic signed [18:0] a_c;
	logic [49:0]        sq3_c;
	logic [50:0]        sq5_c;
	logic [16:0]        t2_c;
	logic [RAW_W-1:0]   d1_s3;
	logic               inv_s3;
	logic signed [18:0] a_s3;
	logic signed [19:0] b_s3;
	logic signed [19:0] temp_s3;
	logic [16:0]        t2_s3;
	logic signed [36:0] off_lin_s3;
	logic signed [35:0] sens_lin_s3;

	assign a_c   = m_ts_s2[41:23];
	assign sq3_c = {1'b0, m_sq_s2, 1'b0} + {2'b0, m_sq_s2};
	assign sq5_c = {1'b0, m_sq_s2, 2'b0} + {3'b0, m_sq_s2};
	assign t2_c  = a_c[18] ? sq3_c[49:33] : {4'b0, sq5_c[50:38]};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			d1_s3       <= d1_s2;
			inv_s3      <= inv_s2;
			a_s3        <= a_c;
			b_s3        <= $signed({a_c[18], a_c}) + 20'(TEMP_REF - TEMP_COLD);
			temp_s3     <= $signed({a_c[18], a_c}) + 20'(TEMP_REF);
			t2_s3       <= t2_c;
			off_lin_s3  <= $signed({4'b0, cal.off_t1, 17'b0})
			             + $signed({m_tco_s2[41], m_tco_s2[41:6]});
			sens_lin_s3 <= $signed({4'b0, cal.sens_t1, 16'b0})
			             + $signed({m_tcs_s2[41], m_tcs_s2[41:7]});
		end
	end

	// Stage 4: squares and the final temperature
	logic signed [37:0] a2_c;
	logic signed [39:0] b2_c;
	logic signed [20:0] t_out_c;
	corr_t              corr_s4;

	assign a2_c    = a_s3 * a_s3;
	assign b2_c    = b_s3 * b_s3;
	assign t_out_c = $signed({temp_s3[19], temp_s3}) - $signed({4'b0, t2_s3});

	always_ff @(posedge clk) begin
		if (en[3]) begin
			corr_s4.inv      <= inv_s3;
			corr_s4.a_neg    <= a_s3[18];
			corr_s4.b_neg    <= b_s3[19];
			corr_s4.d1       <= d1_s3;
			corr_s4.t_out    <= t_out_c;
			corr_s4.off_lin  <= off_lin_s3;
			corr_s4.sens_lin <= sens_lin_s3;
			corr_s4.a2       <= a2_c[33:0];
			corr_s4.b2       <= b2_c[34:0];
		end
	end

	assign corr = corr_s4;

endmodule

// ===== design/ptc_press_path.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_press_path
// Stages 5 to 9: second-order OFF2 and SENS2, final OFF and SENS, the split
// D1 * SENS product, and the saturated pressure with the output register.
// ----------------------------------------------------------------------------
module ptc_press_path (
	input  logic                                  clk,
	input  logic [ptc_pkg::NUM_STAGES-1:0]        en,
	input  ptc_pkg::corr_t                        corr,
	output logic signed [ptc_pkg::TEMP_OUT_W-1:0] temperature_centi,
	output logic signed [ptc_pkg::PRES_OUT_W-1:0] pressure_centi,
	output logic                                  invalid
);
	import ptc_pkg::*;

	// Stage 5: correction terms, zero at or above 20.00 C
	logic [39:0]        off2_a_c;
	logic [38:0]        off2_b_c;
	logic [38:0]        sens2_a_c;
	logic [37:0]        sens2_b_c;
	logic [40:0]        off2_c;
	logic [39:0]        sens2_c;
	logic               inv_s5;
	logic [20:0]        t_out_s5;
	logic [RAW_W-1:0]   d1_s5;
	logic signed [36:0] off_lin_s5;
	logic signed [35:0] sens_lin_s5;
	logic [40:0]        off2_s5;
	logic [39:0]        sens2_s5;

	assign off2_a_c  = 40'(corr.a2) * 40'(OFF2_A_COEF);
	assign sens2_a_c = 39'(corr.a2) * 39'(SENS2_A_COEF);
	assign off2_b_c  = 39'(corr.b2) * 39'(OFF2_B_COEF);
	assign sens2_b_c = 38'(corr.b2) * 38'(SENS2_B_COEF);

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (corr.a_neg) begin
			off2_c  = 41'(off2_a_c[39:4]);
			sens2_c = 40'(sens2_a_c[38:4]);
			if (corr.b_neg) begin
				off2_c  = off2_c + 41'(off2_b_c);
				sens2_c = sens2_c + 40'(sens2_b_c);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			inv_s5      <= corr.inv;
			t_out_s5    <= corr.t_out;
			d1_s5       <= corr.d1;
			off_lin_s5  <= $signed(corr.off_lin);
			sens_lin_s5 <= $signed(corr.sens_lin);
			off2_s5     <= off2_c;
			sens2_s5    <= sens2_c;
		end
	end

	// Stage 6: final OFF and SENS
	logic               inv_s6;
	logic [20:0]        t_out_s6;
	logic [RAW_W-1:0]   d1_s6;
	logic signed [42:0] off_s6;
	logic signed [40:0] sens_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			inv_s6   <= inv_s5;
			t_out_s6 <= t_out_s5;
			d1_s6    <= d1_s5;
			off_s6   <= $signed({{6{off_lin_s5[36]}}, off_lin_s5}) - $signed({2'b0, off2_s5});
			sens_s6  <= $signed({{5{sens_lin_s5[35]}}, sens_lin_s5})
			          - $signed({1'b0, sens2_s5});
		end
	end

	// Stage 7: D1 * SENS as two partial products
	logic               inv_s7;
	logic [20:0]        t_out_s7;
	logic signed [42:0] off_s7;
	logic [43:0]        p_lo_s7;
	logic signed [45:0] p_hi_s7;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			inv_s7   <= inv_s6;
			t_out_s7 <= t_out_s6;
			off_s7   <= off_s6;
			p_lo_s7  <= d1_s6 * sens_s6[19:0];
			p_hi_s7  <= $signed({1'b0, d1_s6}) * $signed(sens_s6[40:20]);
		end
	end

	// Stage 8: combine the partial products
	logic               inv_s8;
	logic [20:0]        t_out_s8;
	logic signed [42:0] off_s8;
	logic signed [65:0] prod_s8;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			inv_s8   <= inv_s7;
			t_out_s8 <= t_out_s7;
			off_s8   <= off_s7;
			prod_s8  <= $signed({p_hi_s7, 20'b0}) + $signed({22'b0, p_lo_s7});
		end
	end

	// Stage 9: subtract OFF, scale, saturate, zero on an invalid reading
	logic signed [47:0] diff_c;
	logic signed [32:0] p_wide_c;
	logic [31:0]        p_sat_c;

	assign diff_c   = $signed({{3{prod_s8[65]}}, prod_s8[65:21]})
	                - $signed({{5{off_s8[42]}}, off_s8});
	assign p_wide_c = diff_c[47:15];

	always_comb begin
		if (p_wide_c[32] != p_wide_c[31]) begin
			p_sat_c = p_wide_c[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			p_sat_c = p_wide_c[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			invalid           <= inv_s8;
			temperature_centi <= inv_s8 ? '0 : $signed(t_out_s8[TEMP_OUT_W-1:0]);
			pressure_centi    <= inv_s8 ? '0 : $signed(p_sat_c);
		end
	end

endmodule

// ===== design/pressure_temperature_compensation_top.sv =====
`timescale 1ns / 1ps
// An accepted item reaches out_valid through the stage 1 to stage 9 registers, in order.
// Throughput: one item per cycle while the output is not stalled; nine register stages.
// An output stall freezes only the full stages with no empty stage after them; the rest keep loading.
// Reset (arst_n low): clears every valid bit and all six calibration words to zero.
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top
// Second-order compensated barometer: raw D1/D2 readings in, temperature and
// pressure in hundredths out, with a zero-reading flag.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input items
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [ptc_pkg::RAW_W-1:0]             raw_pressure,
	input  logic [ptc_pkg::RAW_W-1:0]             raw_temperature,
	// result items
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ptc_pkg::TEMP_OUT_W-1:0] temperature_centi,
	output logic signed [ptc_pkg::PRES_OUT_W-1:0] pressure_centi,
	output logic                                  invalid,
	// calibration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ptc_pkg::CAL_W-1:0]             cfg_data
);
	import ptc_pkg::*;

	cal_t                  cal;
	corr_t                 corr;
	logic [NUM_STAGES-1:0] en;

	// Calibration writes are always taken; the user must write only while idle (not enforced).
	assign cfg_ready = 1'b1;

	ptc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cal       (cal)
	);

	// Valid bits and load enables for all nine stages.
	ptc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.en        (en),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	// Stages 1-4: dT, TEMP, T2, first-order OFF/SENS and the correction squares.
	ptc_temp_path u_temp (
		.clk             (clk),
		.en              (en),
		.cal             (cal),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.corr            (corr)
	);

	// Stages 5-9: second-order correction, D1 * SENS, saturation, output register.
	ptc_press_path u_press (
		.clk               (clk),
		.en                (en),
		.corr              (corr),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi),
		.invalid           (invalid)
	);

endmodule

// ===== design/ptc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_stall,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic signed [ptc_pkg::TEMP_OUT_W-1:0] temperature_centi,
	input logic signed [ptc_pkg::PRES_OUT_W-1:0] pressure_centi,
	input logic                                  invalid,
	input logic                                  cfg_valid,
	input logic                                  cfg_ready
);

	// A stalled result item holds its place and value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pressure_centi)
		&& $stable(temperature_centi) && $stable(invalid))
		else $error("stalled result item changed");

	// The input side backs up only when the pipeline is full behind a stalled output.
	a_in_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while pipeline has room");

	// A zero reading yields zero result fields.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> temperature_centi == '0 && pressure_centi == '0)
		else $error("invalid item carries nonzero fields");

	// Calibration writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("calibration write not taken");

endmodule

bind pressure_temperature_compensation_top ptc_checker u_ptc_checker (.*);

// ===== tb/tb_pressure_temperature_compensation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pressure_temperature_compensation_top
// Self-checking bench for the compensated barometer pipeline. A queue of
// raw D1/D2 pairs feeds a clocked driver. Every accepted pair is run through
// a bit-exact model of the second-order compensation under the calibration
// words currently loaded. A clocked monitor pops the oldest predicted
// reading for each result and compares temperature, pressure and the
// invalid flag. Both sides idle at random. Repeated long output hold-offs
// fill the pipeline and force an input stall.
// ----------------------------------------------------------------------------
module tb_pressure_temperature_compensation_top;
	import ptc_pkg::*;

	// The worst case per pair is the sender gap, receiver stall and pipeline,
	// for roughly 720 pairs, plus hold-offs and calibration loads.
	// Take that several times over.
	localparam int unsigned CYCLE_LIMIT   = 250000;
	localparam int unsigned RAND_PHASES   = 6;
	localparam int unsigned PHASE_ITEMS   = 115;
	localparam int unsigned FIRST_HOLD_AT = 70;
	localparam int unsigned HOLD_SPACING  = 350;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam longint      P_MAX         = 2147483647;
	localparam longint      P_MIN         = -P_MAX - 1;

	// Register indexes the block does not decode; writes to them are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// Idle ceilings per random phase: one stretch with no idling at all,
	// then each side idling alone, then both together.
	localparam int unsigned SEND_IDLE [RAND_PHASES] = '{0, 13, 0, 13, 5, 13};
	localparam int unsigned RECV_IDLE [RAND_PHASES] = '{0, 0, 13, 13, 5, 13};

	typedef struct packed {
		logic [RAW_W-1:0] d1;
		logic [RAW_W-1:0] d2;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_OUT_W-1:0] t_centi;
		logic signed [PRES_OUT_W-1:0] p_centi;
		logic                         inv;
	} reading_t;

	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  in_valid        = 1'b0;
	logic                  in_stall;
	logic [RAW_W-1:0]      raw_pressure    = '0;
	logic [RAW_W-1:0]      raw_temperature = '0;
	logic                  out_valid;
	logic                  out_stall       = 1'b0;
	logic signed [TEMP_OUT_W-1:0] temperature_centi;
	logic signed [PRES_OUT_W-1:0] pressure_centi;
	logic                  invalid;
	logic                  cfg_valid       = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index       = '0;
	logic [CAL_W-1:0]      cfg_data        = '0;

	// Pairs waiting to be sent, and readings predicted for accepted pairs
	sample_t     sample_q[$];
	reading_t    reading_q[$];
	// Calibration words as the block should hold them
	cal_t        cal_model       = '0;

	int unsigned send_idle_max   = 0;
	int unsigned recv_idle_max   = 0;
	int unsigned send_gap        = 0;
	int unsigned recv_wait       = 0;
	int unsigned accepted_count  = 0;
	int unsigned hold_left       = 0;
	int unsigned hold_mark       = FIRST_HOLD_AT;
	int unsigned cycle_count     = 0;
	int unsigned mismatches      = 0;

	pressure_temperature_compensation_top uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.raw_pressure      (raw_pressure),
		.raw_temperature   (raw_temperature),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi),
		.invalid           (invalid),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Second-order compensation of one D1/D2 pair. All arithmetic runs in
	// 64-bit signed; the largest product, D1 * SENS, stays below 2^62.
	// Arithmetic right shifts give the floor; the divide by 16 truncates,
	// but its operand is never negative.
	function automatic reading_t compensate(sample_t s, cal_t c);
		longint   d1, d2, dt, temp, t2, off2, sens2, off, sens, p, a, b, t_out;
		reading_t r;
		r = '0;
		if (s.d1 == '0 || s.d2 == '0) begin
			r.inv = 1'b1;
			return r;
		end
		d1   = s.d1;
		d2   = s.d2;
		dt   = d2 - longint'(c.t_ref) * 256;
		temp = TEMP_REF + ((dt * longint'(c.temp_sens)) >>> 23);
		if (temp < TEMP_REF) begin
			a     = temp - TEMP_REF;
			t2    = (3 * (dt * dt)) >>> 33;
			off2  = (OFF2_A_COEF * a * a) / 16;
			sens2 = (SENS2_A_COEF * a * a) / 16;
			// below -15.00 C the stronger terms pile on
			if (temp < TEMP_COLD) begin
				b     = temp - TEMP_COLD;
				off2  = off2 + OFF2_B_COEF * b * b;
				sens2 = sens2 + SENS2_B_COEF * b * b;
			end
		end else begin
			t2    = (5 * (dt * dt)) >>> 38;
			off2  = 0;
			sens2 = 0;
		end
		off  = longint'(c.off_t1) * 131072 + ((longint'(c.tco) * dt) >>> 6) - off2;
		sens = longint'(c.sens_t1) * 65536 + ((longint'(c.tcs) * dt) >>> 7) - sens2;
		p    = (((d1 * sens) >>> 21) - off) >>> 15;
		if (p > P_MAX) p = P_MAX;
		if (p < P_MIN) p = P_MIN;
		t_out     = temp - t2;
		r.t_centi = t_out[TEMP_OUT_W-1:0];
		r.p_centi = p[PRES_OUT_W-1:0];
		return r;
	endfunction

	// Half the items go straight through; the rest wait up to the ceiling
	function automatic int unsigned draw_gap(int unsigned ceiling);
		if (ceiling == 0 || $urandom_range(0, 1) == 0) return 0;
		return $urandom_range(0, ceiling);
	endfunction

	function automatic logic [CAL_W-1:0] random_word();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return CAL_W'($urandom);
		endcase
	endfunction

	// D2 lands near the reference point in four draws of ten so that warm, cool
	// and cold branches all see traffic; the rest is zero, all ones or the full field.
	function automatic sample_t random_sample(logic [CAL_W-1:0] t_ref);
		sample_t s;
		longint  near_ref;
		case ($urandom_range(0, 9))
			0: s.d1 = '0;
			1: s.d1 = '1;
			2: s.d1 = 24'd1;
			default: s.d1 = RAW_W'($urandom);
		endcase
		near_ref = longint'(t_ref) * 256 + longint'($urandom_range(0, 3 * 2 ** 20)) - 2 ** 21;
		case ($urandom_range(0, 9))
			0: s.d2 = '0;
			1: s.d2 = '1;
			2, 3, 4, 5: s.d2 = near_ref[RAW_W-1:0];
			default: s.d2 = RAW_W'($urandom);
		endcase
		return s;
	endfunction

	task automatic flag_mismatch(string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic offer(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
		sample_t s;
		s.d1 = d1;
		s.d2 = d2;
		sample_q.push_back(s);
	endtask

	// One register write: raise valid at an edge, hold until ready is seen
	// at an edge, then drop valid. The model copy follows the write; unknown
	// indexes leave it alone.
	task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SENS_T1:   cal_model.sens_t1   = val;
			CFG_OFF_T1:    cal_model.off_t1    = val;
			CFG_TCS:       cal_model.tcs       = val;
			CFG_TCO:       cal_model.tco       = val;
			CFG_T_REF:     cal_model.t_ref     = val;
			CFG_TEMP_SENS: cal_model.temp_sens = val;
			default: ;
		endcase
	endtask

	task automatic load_cal(cal_t c);
		write_cal(CFG_SENS_T1, c.sens_t1);
		write_cal(CFG_OFF_T1, c.off_t1);
		write_cal(CFG_TCS, c.tcs);
		write_cal(CFG_TCO, c.tco);
		write_cal(CFG_T_REF, c.t_ref);
		write_cal(CFG_TEMP_SENS, c.temp_sens);
	endtask

	// Wait until every queued pair is sent and every reading is back, then
	// let the pipeline settle before anything touches the registers.
	task automatic drain();
		while (sample_q.size() != 0 || in_valid || reading_q.size() != 0)
			@(negedge clk);
		repeat (NUM_STAGES + 2) @(negedge clk);
	endtask

	// Driver: predict on acceptance, then present the next pair once the
	// current one is gone and the drawn gap has run out. A stalled pair is
	// held as it is.
	always @(posedge clk or negedge arst_n) begin
		sample_t cur;
		sample_t nxt;
		if (!arst_n) begin
			in_valid        <= 1'b0;
			raw_pressure    <= '0;
			raw_temperature <= '0;
			send_gap        <= 0;
			accepted_count  <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				cur.d1 = raw_pressure;
				cur.d2 = raw_temperature;
				reading_q.push_back(compensate(cur, cal_model));
				accepted_count <= accepted_count + 1;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (sample_q.size() != 0) begin
					nxt = sample_q.pop_front();
					in_valid        <= 1'b1;
					raw_pressure    <= nxt.d1;
					raw_temperature <= nxt.d2;
					send_gap        <= draw_gap(send_idle_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here on its own. It fires each time a
	// further set number of pairs has gone in, while the sender is still offering, so
	// the nine stages fill up and the input has to stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_mark <= FIRST_HOLD_AT;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (accepted_count >= hold_mark) begin
			hold_left <= HOLD_CYCLES;
			hold_mark <= hold_mark + HOLD_SPACING;
		end
	end

	// Monitor: check each accepted reading against the oldest prediction,
	// then draw how long to stall before taking the next one.
	always @(posedge clk or negedge arst_n) begin
		reading_t    want;
		int unsigned w;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait <= 0;
		end else begin
			w = recv_wait;
			if (out_valid && !out_stall) begin
				if (reading_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected reading T=%0d P=%0d invalid=%0b",
						temperature_centi, pressure_centi, invalid));
				end else begin
					want = reading_q.pop_front();
					if (temperature_centi !== want.t_centi)
						flag_mismatch($sformatf("temperature_centi %0d, want %0d",
							temperature_centi, want.t_centi));
					if (pressure_centi !== want.p_centi)
						flag_mismatch($sformatf("pressure_centi %0d, want %0d",
							pressure_centi, want.p_centi));
					if (invalid !== want.inv)
						flag_mismatch($sformatf("invalid %0b, want %0b", invalid, want.inv));
				end
				w = draw_gap(recv_idle_max);
			end
			out_stall <= (w != 0) || (hold_left != 0);
			recv_wait <= (w != 0) ? w - 1 : 0;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_pressure_temperature_compensation_top: FAIL");
			$finish;
		end
	end

	initial begin
		cal_t cal_set;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Calibration words still at their reset value of zero
		offer(24'd6465444, 24'd8077636);
		offer(24'd0, 24'd5);
		offer(24'hFFFFFF, 24'hFFFFFF);
		offer(24'd1, 24'd1);
		drain();

		// Typical factory words; the spare indexes must not disturb them
		send_idle_max = 13;
		recv_idle_max = 13;
		cal_set.sens_t1   = 16'd46372;
		cal_set.off_t1    = 16'd43981;
		cal_set.tcs       = 16'd29059;
		cal_set.tco       = 16'd27842;
		cal_set.t_ref     = 16'd31553;
		cal_set.temp_sens = 16'd28165;
		load_cal(cal_set);
		write_cal(CFG_SPARE_LO, 16'hFFFF);
		write_cal(CFG_SPARE_HI, 16'hFFFF);
		@(negedge clk);
		offer(24'd6465444, 24'd8077636);   // room temperature
		offer(24'd0, 24'd8077636);         // zero pressure reading
		offer(24'd6465444, 24'd0);         // zero temperature reading
		offer(24'd0, 24'd0);
		offer(24'hFFFFFF, 24'hFFFFFF);
		offer(24'd1, 24'd1);
		offer(24'hFFFFFF, 24'd1);
		offer(24'd1, 24'hFFFFFF);
		offer(24'd6465444, 24'd8077568);   // exactly 20.00 C: warm branch
		offer(24'd6465444, 24'd8077567);   // 19.99 C: first cold branch
		offer(24'd6465444, 24'd7035135);   // exactly -15.00 C: not yet the strong terms
		offer(24'd6465444, 24'd7035134);   // -15.01 C: strong terms on
		offer(24'd5000000, 24'd6000000);   // deep cold
		offer(24'h800000, 24'h7FFFFF);
		offer(24'hAAAAAA, 24'h555555);
		offer(24'h555555, 24'hAAAAAA);
		offer(24'h7FFFFF, 24'h800000);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			send_idle_max = SEND_IDLE[ph];
			recv_idle_max = RECV_IDLE[ph];
			if (ph == 0)
				cal_set = '1;
			else if (ph == 1)
				cal_set = '0;
			else begin
				cal_set.sens_t1   = random_word();
				cal_set.off_t1    = random_word();
				cal_set.tcs       = random_word();
				cal_set.tco       = random_word();
				cal_set.t_ref     = random_word();
				cal_set.temp_sens = random_word();
			end
			load_cal(cal_set);
			if ($urandom_range(0, 1) != 0)
				write_cal(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
					CAL_W'($urandom));
			@(negedge clk);
			repeat (PHASE_ITEMS) sample_q.push_back(random_sample(cal_model.t_ref));
		end

		// Everything sent: wait for the last readings, then give any stray
		// result time to show up.
		drain();
		repeat (3 * NUM_STAGES) @(negedge clk);
		if (reading_q.size() != 0)
			flag_mismatch($sformatf("%0d predicted readings never arrived", reading_q.size()));

		if (mismatches == 0)
			$display("tb_pressure_temperature_compensation_top: PASS");
		else
			$display("tb_pressure_temperature_compensation_top: FAIL");
		$finish;
	end

endmodule

// ===== pressure_temperature_compensation_top.f =====
design/ptc_pkg.sv
design/ptc_cfg_regs.sv
design/ptc_pipe_ctrl.sv
design/ptc_temp_path.sv
design/ptc_press_path.sv
design/pressure_temperature_compensation_top.sv
design/ptc_checker.sv
tb/tb_pressure_temperature_compensation_top.sv
